// File: design/bdq_pkg.sv
// Shared types and constants for the byte deque ring.
package bdq_pkg;

  localparam int Depth = 16;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int OccW  = 5;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ_ALL   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } cell_tap_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      out_value;
    logic [1:0]      status;
    logic [OccW-1:0] occupancy;
    logic            last_of_run;
  } out_item_t;

endpackage

// File: design/bdq_cell.sv
// One storage cell of the deque chain, exchanging its byte with both neighbours.
module bdq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bdq_pkg::cell_op_e   op_i,
  input  logic [7:0]          push_value_i,
  input  logic [7:0]          head_i,
  input  bdq_pkg::cell_tap_t  left_i,
  input  bdq_pkg::cell_tap_t  right_i,
  output bdq_pkg::cell_tap_t  tap_o
);
  import bdq_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    unique case (op_i)
      OP_HOLD: begin
      end
      OP_PUSH_FRONT: begin
        valid_d = left_i.valid;
        data_d  = left_i.data;
      end
      OP_PUSH_BACK: begin
        if (!valid_q && left_i.valid) begin
          valid_d = 1'b1;
          data_d  = push_value_i;
        end
      end
      OP_POP_FRONT: begin
        valid_d = right_i.valid;
        data_d  = right_i.data;
      end
      OP_POP_BACK: begin
        if (valid_q && !right_i.valid) begin
          valid_d = 1'b0;
        end
      end
      OP_ROTATE: begin
        if (valid_q) begin
          data_d = right_i.valid ? right_i.data : head_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign tap_o.valid = valid_q;
  assign tap_o.data  = data_q;

endmodule

// File: design/byte_deque_ring.sv
// Top level of the byte deque: a chain of storage cells with a sequencing controller.
// Push and pop requests are handled in the idle state; their result is registered at the accepting edge.
// A read-all of N stored bytes is accepted first, then gives one result per cycle while the
// output is not stalled, as the cell chain rotates its contents past the front cell.
// A new request is taken once the previous one has loaded its last result and the output is free.
// Reset empties the deque at once; stored bytes themselves are not cleared.
module byte_deque_ring (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bdq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bdq_pkg::out_item_t out_item_o
);
  import bdq_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] left_q, left_d;
  out_item_t       out_q, res;
  logic            out_valid_q;
  logic            load;
  logic            out_free;
  logic            accept;
  logic            full, empty;
  cell_op_e        cell_op;
  logic [7:0]      back_byte;
  logic [Depth-1:0] valid_vec;

  cell_tap_t tap      [Depth];
  cell_tap_t left_tap [Depth];
  cell_tap_t right_tap[Depth];

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (i == 0) begin
        left_tap[i].valid = 1'b1;
        left_tap[i].data  = in_item_i.push_value;
      end else begin
        left_tap[i] = tap[i-1];
      end
      if (i == Depth - 1) begin
        right_tap[i].valid = 1'b0;
        right_tap[i].data  = 8'd0;
      end else begin
        right_tap[i] = tap[i+1];
      end
    end
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    bdq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (cell_op),
      .push_value_i(in_item_i.push_value),
      .head_i      (tap[0].data),
      .left_i      (left_tap[g]),
      .right_i     (right_tap[g]),
      .tap_o       (tap[g])
    );
    assign valid_vec[g] = tap[g].valid;
  end

  always_comb begin
    back_byte = 8'd0;
    for (int i = 0; i < Depth; i++) begin
      if (tap[i].valid && !right_tap[i].valid) begin
        back_byte = back_byte | tap[i].data;
      end
    end
  end

  assign full     = (count_q == CntW'(Depth));
  assign empty    = (count_q == '0);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    left_d          = left_q;
    cell_op         = OP_HOLD;
    load            = 1'b0;
    res.out_value   = 8'd0;
    res.status      = STATUS_OK;
    res.last_of_run = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_e'(in_item_i.req_type))
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              load = 1'b1;
              if (full) begin
                res.status = STATUS_FULL;
              end else begin
                cell_op = (req_e'(in_item_i.req_type) == REQ_PUSH_FRONT) ?
                          OP_PUSH_FRONT : OP_PUSH_BACK;
                count_d = count_q + CntW'(1);
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              load = 1'b1;
              if (empty) begin
                res.status = STATUS_EMPTY;
              end else if (req_e'(in_item_i.req_type) == REQ_POP_FRONT) begin
                cell_op       = OP_POP_FRONT;
                res.out_value = tap[0].data;
                count_d       = count_q - CntW'(1);
              end else begin
                cell_op       = OP_POP_BACK;
                res.out_value = back_byte;
                count_d       = count_q - CntW'(1);
              end
            end
            REQ_READ_ALL: begin
              if (empty) begin
                load       = 1'b1;
                res.status = STATUS_EMPTY;
              end else begin
                state_d = ST_DUMP;
                left_d  = count_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          load            = 1'b1;
          cell_op         = OP_ROTATE;
          res.out_value   = tap[0].data;
          res.last_of_run = (left_q == CntW'(1));
          left_d          = left_q - CntW'(1);
          if (left_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    res.occupancy = OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      left_q  <= left_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("occupancy count differs from the number of filled cells");

  a_dump_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (left_q != '0 && !empty))
    else $error("read-out running with nothing left to send");

  a_dump_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP && load && left_q == CntW'(1)) |=> (state_q == ST_IDLE))
    else $error("read-out did not return to idle after its last item");

  a_dump_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |=> $stable(count_q))
    else $error("occupancy changed during a read-out");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the byte deque ring, driven through its valid and stall handshakes.
`timescale 1ns / 1ps

module testbench;
  import bdq_pkg::*;

  localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
  localparam int ItemsPerPhase  = 90;
  localparam int HoldOffCycles  = 80;
  localparam int DrainCycles    = 40;
  localparam int WatchdogLimit  = 4000;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } request_mix_e;

  class deque_scoreboard;
    logic [7:0] ring_bytes [Depth];
    int         head_pos;
    int         fill_level;
    out_item_t  expected_results [$];
    int         mismatches;

    function new();
      head_pos   = 0;
      fill_level = 0;
      mismatches = 0;
    endfunction

    function void expect_result(logic [7:0] value, status_e st, logic last);
      out_item_t res;
      res.out_value   = value;
      res.status      = st;
      res.occupancy   = OccW'(fill_level);
      res.last_of_run = last;
      expected_results.push_back(res);
    endfunction

    function void note_request(in_item_t req);
      int slot;
      case (req.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (fill_level >= Depth) begin
            expect_result(8'd0, STATUS_FULL, 1'b1);
          end else begin
            if (req.req_type == REQ_PUSH_FRONT) begin
              head_pos = (head_pos + Depth - 1) % Depth;
              ring_bytes[head_pos] = req.push_value;
            end else begin
              ring_bytes[(head_pos + fill_level) % Depth] = req.push_value;
            end
            fill_level++;
            expect_result(8'd0, STATUS_OK, 1'b1);
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (fill_level == 0) begin
            expect_result(8'd0, STATUS_EMPTY, 1'b1);
          end else begin
            if (req.req_type == REQ_POP_FRONT) begin
              slot     = head_pos;
              head_pos = (head_pos + 1) % Depth;
            end else begin
              slot = (head_pos + fill_level - 1) % Depth;
            end
            fill_level--;
            expect_result(ring_bytes[slot], STATUS_OK, 1'b1);
          end
        end
        REQ_READ_ALL: begin
          if (fill_level == 0) begin
            expect_result(8'd0, STATUS_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < fill_level; i++) begin
              expect_result(ring_bytes[(head_pos + i) % Depth], STATUS_OK,
                            i + 1 == fill_level);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, got %0d", field, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: out_value %0d, status %0d",
               got.out_value, got.status);
        mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        compare_field("out_value", exp_res.out_value, got.out_value);
        compare_field("status", exp_res.status, got.status);
        compare_field("occupancy", exp_res.occupancy, got.occupancy);
        compare_field("last_of_run", exp_res.last_of_run, got.last_of_run);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  deque_scoreboard deque_sb = new();
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_off_req;
  int   requests_sent;

  byte_deque_ring dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic in_item_t make_request(logic [2:0] code, logic [7:0] value);
    in_item_t req;
    req.req_type   = code;
    req.push_value = value;
    return req;
  endfunction

  function automatic in_item_t random_request(request_mix_e mix);
    int push_pct;
    int pop_pct;
    int pick;
    logic [2:0] code;
    push_pct = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 25 : 40;
    pop_pct  = (mix == MIX_FILL) ? 25 : (mix == MIX_DRAIN) ? 60 : 40;
    pick     = $urandom_range(99);
    if (pick < push_pct) begin
      code = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    end else if (pick < push_pct + pop_pct) begin
      code = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
    end else if (pick < 96) begin
      code = REQ_READ_ALL;
    end else begin
      code = 3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
    end
    return make_request(code, 8'($urandom_range(255)));
  endfunction

  task automatic send_request(input in_item_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    deque_sb.note_request(req);
    if (req.req_type <= REQ_READ_ALL) begin
      requests_sent++;
    end
  endtask

  task automatic run_directed();
    send_request(make_request(REQ_POP_FRONT, 8'hFF));
    send_request(make_request(REQ_POP_BACK, 8'h00));
    send_request(make_request(REQ_READ_ALL, 8'h5A));
    send_request(make_request(REQ_UNUSED_LAST, 8'hFF));
    send_request(make_request(REQ_PUSH_FRONT, 8'h00));
    send_request(make_request(REQ_PUSH_BACK, 8'hFF));
    send_request(make_request(REQ_READ_ALL, 8'h00));
    send_request(make_request(REQ_POP_FRONT, 8'h00));
    send_request(make_request(REQ_POP_BACK, 8'h00));
    for (int i = 0; i < Depth; i++) begin
      send_request(make_request(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                                8'(i * 8'h11)));
    end
    send_request(make_request(REQ_PUSH_FRONT, 8'hA5));
    send_request(make_request(REQ_PUSH_BACK, 8'h5A));
    send_request(make_request(REQ_READ_ALL, 8'h00));
  endtask

  task automatic run_random(input int target);
    request_mix_e mix;
    int burst_left;
    burst_left = 0;
    mix        = MIX_FILL;
    while (requests_sent < target) begin
      if (burst_left == 0) begin
        mix        = request_mix_e'($urandom_range(MIX_EVEN, MIX_FILL));
        burst_left = $urandom_range(30, 10);
      end
      burst_left--;
      send_request(random_request(mix));
    end
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        deque_sb.check_result(out_item_o);
      end
      if (hold_off_req) begin
        hold_left = HoldOffCycles;
        hold_off_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    in_item_i     <= '0;
    hold_off_req  <= 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 47;
    requests_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(ItemsPerPhase);

    send_idle_pct = 47;
    recv_idle_pct = 28;
    run_random(2 * ItemsPerPhase);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req <= 1'b1;
    run_random(3 * ItemsPerPhase);

    in_valid_i <= 1'b0;
    while (deque_sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (deque_sb.mismatches == 0 && deque_sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/bdq_pkg.sv
design/bdq_cell.sv
design/byte_deque_ring.sv
tb/testbench.sv
